// ===== hdl/bit_field_unit_access_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Bit field unit access sequencer assertion macros
// Concurrent check shorthands used by the top RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef BIT_FIELD_UNIT_ACCESS_SEQUENCER_TOP_MACROS_SVH
`define BIT_FIELD_UNIT_ACCESS_SEQUENCER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BFU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bfu_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit field unit access package
// Shared codes, types and mask helper of the bit field unit access sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bfu_pkg;

    // widths
    localparam int DATA_W         = 64;
    localparam int ADDR_W         = 32;
    localparam int MAX_FIELD_BITS = 64;

    // commands on the input side
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_RD_REQ = 2'd0;
    localparam logic [1:0] KIND_WR_REQ = 2'd1;
    localparam logic [1:0] KIND_VALUE  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_BOUNDS = 2'd1;
    localparam logic [1:0] ERR_BUSY   = 2'd2;

    // update rules
    localparam logic [1:0] RULE_PRESERVE = 2'd0;
    localparam logic [1:0] RULE_ONES     = 2'd1;

    // register indexes
    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_ACCESS = 2'd2;
    localparam logic [1:0] REG_RULE   = 2'd3;

    // field configuration
    typedef struct packed {
        logic [ADDR_W-1:0] start_bit;
        logic [7:0]        field_len;
        logic [1:0]        access_code;
        logic [1:0]        update_rule;
    } t_cfg;

    // per unit results of the shared span unit
    typedef struct packed {
        logic [ADDR_W-1:0] byte_off;
        logic              partial;
        logic [DATA_W-1:0] wr_word;
        logic [DATA_W-1:0] rd_bits;
    } t_unit_res;

    // low n bits set, all bits for n of the data width or more
    function automatic logic [DATA_W-1:0] f_mask(input logic [7:0] n);
        logic [DATA_W-1:0] m;
        if (n >= 8'(DATA_W)) begin
            m = '1;
        end else begin
            m = (DATA_W'(1) << n) - DATA_W'(1);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bit_field_unit_access_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Bit field unit access sequencer
// Splits a configured bit field into aligned bus access units and sequences
// the unit reads and writes of field read and write requests.
// ----------------------------------------------------------------------------
// A field read emits one unit read request at a time and waits for the
// returned unit word (command 2) before the next; after the final unit the
// field value comes out with last set. A field write first captures the
// value and then emits one unit write per cycle while the output slot is
// free, handled by a single shared span unit that works on one access unit
// per cycle; with the preserve rule each partial unit first emits a unit
// read and waits for its data. A field write therefore holds the input side
// while its unit writes are emitted, and one to eleven results come out per
// request. Errors (bounds, busy or stray data) are a single result with last
// set. The input side is not ready while unit writes are being emitted, nor
// while a result waits at the output. Register writes are taken only when
// no field operation is pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_field_unit_access_sequencer_top_macros.svh"

module bit_field_unit_access_sequencer_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write port
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_wdata,
    // request side
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // [63:0] data
    input  wire logic [1:0]   s_axis_tuser,   // [1:0] command
    // result side
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata,   // [31:0] byte_offset, [33:32] width_code,
                                              // [97:34] payload, [99:98] error_code,
                                              // [103:100] zero
    output logic [1:0]        m_axis_tuser,   // [1:0] kind
    output logic              m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_WAIT,
        S_PR_WAIT,
        S_WRITE
    } t_state;

    t_state                      r_state, n_state;
    bfu_pkg::t_cfg               r_cfg;
    logic [bfu_pkg::ADDR_W-1:0]  r_unit_index, n_unit_index;
    logic [bfu_pkg::ADDR_W-1:0]  r_final_unit, n_final_unit;
    logic [bfu_pkg::DATA_W-1:0]  r_assembled, n_assembled;
    logic [bfu_pkg::DATA_W-1:0]  r_pending, n_pending;
    logic                        r_out_valid, n_out_valid;
    logic [1:0]                  r_kind, n_kind;
    logic [bfu_pkg::ADDR_W-1:0]  r_byte_off, n_byte_off;
    logic [1:0]                  r_width, n_width;
    logic [bfu_pkg::DATA_W-1:0]  r_payload, n_payload;
    logic [1:0]                  r_err, n_err;
    logic                        r_last, n_last;

    logic                        w_in_acc;
    logic                        w_slot_free;
    logic [1:0]                  w_cmd;
    logic [2:0]                  w_shamt;
    logic [bfu_pkg::ADDR_W:0]    w_end;
    logic                        w_bounds_bad;
    logic [bfu_pkg::ADDR_W-1:0]  w_first_unit;
    logic [bfu_pkg::ADDR_W-1:0]  w_final_unit;
    logic [bfu_pkg::ADDR_W-1:0]  w_idx_inc;
    logic [bfu_pkg::DATA_W-1:0]  w_word;
    logic [bfu_pkg::DATA_W-1:0]  w_merged;
    logic                        w_is_final;
    bfu_pkg::t_unit_res          w_unit;

    // handshakes
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state != S_WRITE) && w_slot_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = s_axis_tuser;

    // field bounds and unit range
    assign w_shamt      = 3'd3 + {1'b0, r_cfg.access_code};
    assign w_end        = {1'b0, r_cfg.start_bit}
                        + {{(bfu_pkg::ADDR_W-7){1'b0}}, r_cfg.field_len};
    assign w_bounds_bad = (r_cfg.field_len == '0)
                       || (r_cfg.field_len > 8'(bfu_pkg::MAX_FIELD_BITS))
                       || (w_end > {1'b1, {bfu_pkg::ADDR_W{1'b0}}});
    assign w_first_unit = r_cfg.start_bit >> w_shamt;
    assign w_final_unit = bfu_pkg::ADDR_W'((w_end - 1'b1) >> w_shamt);
    assign w_idx_inc    = r_unit_index + 1'b1;
    assign w_is_final   = (r_unit_index == r_final_unit);

    // fill word for unit writes, returned data otherwise
    assign w_word = (r_state == S_WRITE)
                  ? ((r_cfg.update_rule == bfu_pkg::RULE_ONES) ? '1 : '0)
                  : s_axis_tdata;

    // shared span unit
    bfu_unit u_unit (
        .i_unit  (r_unit_index),
        .i_cfg   (r_cfg),
        .i_word  (w_word),
        .i_value (r_pending),
        .o_res   (w_unit)
    );

    assign w_merged = r_assembled | w_unit.rd_bits;

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_unit_index = r_unit_index;
        n_final_unit = r_final_unit;
        n_assembled  = r_assembled;
        n_pending    = r_pending;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_kind       = r_kind;
        n_byte_off   = r_byte_off;
        n_width      = r_width;
        n_payload    = r_payload;
        n_err        = r_err;
        n_last       = r_last;

        if (w_in_acc) begin
            // default result is a busy error
            n_out_valid = 1'b1;
            n_kind      = bfu_pkg::KIND_ERROR;
            n_byte_off  = '0;
            n_width     = '0;
            n_payload   = '0;
            n_err       = bfu_pkg::ERR_BUSY;
            n_last      = 1'b1;
            priority if ((w_cmd == bfu_pkg::CMD_READ) || (w_cmd == bfu_pkg::CMD_WRITE)) begin
                if (r_state == S_IDLE) begin
                    if (w_bounds_bad) begin
                        n_err = bfu_pkg::ERR_BOUNDS;
                    end else begin
                        n_unit_index = w_first_unit;
                        n_final_unit = w_final_unit;
                        if (w_cmd == bfu_pkg::CMD_READ) begin
                            n_assembled = '0;
                            n_state     = S_RD_WAIT;
                            n_kind      = bfu_pkg::KIND_RD_REQ;
                            n_byte_off  = w_first_unit << r_cfg.access_code;
                            n_width     = r_cfg.access_code;
                            n_err       = bfu_pkg::ERR_OK;
                            n_last      = 1'b0;
                        end else begin
                            n_pending   = s_axis_tdata;
                            n_state     = S_WRITE;
                            n_out_valid = r_out_valid && !m_axis_tready;
                            n_kind      = r_kind;
                            n_byte_off  = r_byte_off;
                            n_width     = r_width;
                            n_payload   = r_payload;
                            n_err       = r_err;
                            n_last      = r_last;
                        end
                    end
                end
            end else if ((w_cmd == bfu_pkg::CMD_DATA) && (r_state == S_RD_WAIT)) begin
                n_err  = bfu_pkg::ERR_OK;
                if (w_is_final) begin
                    n_state   = S_IDLE;
                    n_kind    = bfu_pkg::KIND_VALUE;
                    n_payload = w_merged & bfu_pkg::f_mask(r_cfg.field_len);
                    n_last    = 1'b1;
                end else begin
                    n_assembled  = w_merged;
                    n_unit_index = w_idx_inc;
                    n_kind       = bfu_pkg::KIND_RD_REQ;
                    n_byte_off   = w_idx_inc << r_cfg.access_code;
                    n_width      = r_cfg.access_code;
                    n_last       = 1'b0;
                end
            end else if ((w_cmd == bfu_pkg::CMD_DATA) && (r_state == S_PR_WAIT)) begin
                n_kind     = bfu_pkg::KIND_WR_REQ;
                n_byte_off = w_unit.byte_off;
                n_width    = r_cfg.access_code;
                n_payload  = w_unit.wr_word;
                n_err      = bfu_pkg::ERR_OK;
                n_last     = w_is_final;
                if (w_is_final) begin
                    n_state = S_IDLE;
                end else begin
                    n_unit_index = w_idx_inc;
                    n_state      = S_WRITE;
                end
            end else begin
                // stray data or unknown command keeps the busy error
                n_state = r_state;
            end
        end else if ((r_state == S_WRITE) && w_slot_free) begin
            // one unit per cycle while the output slot is free
            n_out_valid = 1'b1;
            n_byte_off  = w_unit.byte_off;
            n_width     = r_cfg.access_code;
            n_err       = bfu_pkg::ERR_OK;
            if (w_unit.partial && (r_cfg.update_rule == bfu_pkg::RULE_PRESERVE)) begin
                n_kind    = bfu_pkg::KIND_RD_REQ;
                n_payload = '0;
                n_last    = 1'b0;
                n_state   = S_PR_WAIT;
            end else begin
                n_kind    = bfu_pkg::KIND_WR_REQ;
                n_payload = w_unit.wr_word;
                n_last    = w_is_final;
                if (w_is_final) begin
                    n_state = S_IDLE;
                end else begin
                    n_unit_index = w_idx_inc;
                end
            end
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_unit_index <= '0;
            r_final_unit <= '0;
            r_assembled  <= '0;
            r_pending    <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_unit_index <= n_unit_index;
            r_final_unit <= n_final_unit;
            r_assembled  <= n_assembled;
            r_pending    <= n_pending;
        end
        r_kind     <= n_kind;
        r_byte_off <= n_byte_off;
        r_width    <= n_width;
        r_payload  <= n_payload;
        r_err      <= n_err;
        r_last     <= n_last;
    end

    // configuration registers, writes ignored while an operation is pending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_bit   <= '0;
            r_cfg.field_len   <= 8'd8;
            r_cfg.access_code <= '0;
            r_cfg.update_rule <= bfu_pkg::RULE_PRESERVE;
        end else if (i_cfg_we && (r_state == S_IDLE)) begin
            unique case (i_cfg_index)
                bfu_pkg::REG_OFFSET: r_cfg.start_bit   <= i_cfg_wdata;
                bfu_pkg::REG_LENGTH: r_cfg.field_len   <= i_cfg_wdata[7:0];
                bfu_pkg::REG_ACCESS: r_cfg.access_code <= i_cfg_wdata[1:0];
                bfu_pkg::REG_RULE:   r_cfg.update_rule <= i_cfg_wdata[1:0];
                default:             r_cfg.start_bit   <= r_cfg.start_bit;
            endcase
        end
    end

    // result port
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {4'b0000, r_err, r_payload, r_width, r_byte_off};

    // checks
    `BFU_ASSERT_SAME(a_write_index_range, i_clk, i_rst_n, (r_state == S_WRITE), (r_unit_index <= r_final_unit), "unit index past final unit during writes")
    `BFU_ASSERT_SAME(a_preserve_read_issued, i_clk, i_rst_n, $rose(r_state == S_PR_WAIT), (r_out_valid && (r_kind == bfu_pkg::KIND_RD_REQ)), "preserve wait without unit read request")
    `BFU_ASSERT_NEXT(a_read_starts, i_clk, i_rst_n, (w_in_acc && (w_cmd == bfu_pkg::CMD_READ) && (r_state == S_IDLE) && !w_bounds_bad), ((r_state == S_RD_WAIT) && r_out_valid && (r_kind == bfu_pkg::KIND_RD_REQ)), "field read did not issue a unit read")
    `BFU_ASSERT_SAME(a_error_shape, i_clk, i_rst_n, (r_out_valid && (r_kind == bfu_pkg::KIND_ERROR)), (r_last && (r_payload == '0) && (r_err != bfu_pkg::ERR_OK)), "malformed error result")

endmodule

`default_nettype wire

// ===== hdl/bfu_unit.sv =====
// ----------------------------------------------------------------------------
// Bit field unit span datapath
// Locates the field inside one access unit, builds unit write data and
// extracts field bits from returned unit data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfu_unit (
    input  wire logic [bfu_pkg::ADDR_W-1:0] i_unit,
    input  wire bfu_pkg::t_cfg              i_cfg,
    input  wire logic [bfu_pkg::DATA_W-1:0] i_word,
    input  wire logic [bfu_pkg::DATA_W-1:0] i_value,
    output bfu_pkg::t_unit_res              o_res
);

    logic [6:0]                  w_acc_bits;
    logic [2:0]                  w_shamt;
    logic [bfu_pkg::ADDR_W:0]    w_ustart;
    logic [bfu_pkg::ADDR_W:0]    w_uend;
    logic [bfu_pkg::ADDR_W:0]    w_off;
    logic [bfu_pkg::ADDR_W:0]    w_fend;
    logic [bfu_pkg::ADDR_W:0]    w_ss;
    logic [bfu_pkg::ADDR_W:0]    w_se;
    logic [5:0]                  w_sh;
    logic [5:0]                  w_pos;
    logic [6:0]                  w_cnt;
    logic [bfu_pkg::DATA_W-1:0]  w_cnt_mask;
    logic [bfu_pkg::DATA_W-1:0]  w_unit_mask;
    logic [bfu_pkg::DATA_W-1:0]  w_m;
    logic [bfu_pkg::DATA_W-1:0]  w_bits;
    logic [bfu_pkg::DATA_W-1:0]  w_base;

    // unit bounds in bit positions
    assign w_acc_bits = 7'd8 << i_cfg.access_code;
    assign w_shamt    = 3'd3 + {1'b0, i_cfg.access_code};
    assign w_ustart   = {1'b0, i_unit} << w_shamt;
    assign w_uend     = w_ustart + {{(bfu_pkg::ADDR_W-6){1'b0}}, w_acc_bits};
    assign w_off      = {1'b0, i_cfg.start_bit};
    assign w_fend     = w_off + {{(bfu_pkg::ADDR_W-7){1'b0}}, i_cfg.field_len};

    // overlap of field and unit
    always_comb begin
        w_ss = (w_ustart > w_off) ? w_ustart : w_off;
        w_se = (w_uend > w_fend) ? w_fend : w_uend;
        if (w_se <= w_ss) begin
            w_sh  = '0;
            w_pos = '0;
            w_cnt = '0;
        end else begin
            w_sh  = 6'(w_ss - w_ustart);
            w_pos = 6'(w_ss - w_off);
            w_cnt = 7'(w_se - w_ss);
        end
    end

    // masks and merge
    assign w_cnt_mask  = bfu_pkg::f_mask({1'b0, w_cnt});
    assign w_unit_mask = bfu_pkg::f_mask({1'b0, w_acc_bits});
    assign w_m         = w_cnt_mask << w_sh;
    assign w_bits      = (i_value >> w_pos) & w_cnt_mask;
    assign w_base      = i_word & w_unit_mask;

    assign o_res.byte_off = i_unit << i_cfg.access_code;
    assign o_res.partial  = (w_cnt != w_acc_bits);
    assign o_res.wr_word  = (w_base & ~w_m) | ((w_bits << w_sh) & w_m);
    assign o_res.rd_bits  = ((i_word >> w_sh) & w_cnt_mask) << w_pos;

endmodule

`default_nettype wire
